/* rtl/tqvg_pkg.sv */
// ---------------------------------------------------------------------------
// tqvg_pkg
// Types, register indexes and widths shared by the tile quad vertex generator.
// ---------------------------------------------------------------------------
package tqvg_pkg;

    localparam int IDX_W       = 16;  // tile index, tile value, sprite number
    localparam int DIV_W       = 11;  // layer width, tileset columns, remainders
    localparam int PIX_W       = 9;   // tile width and height
    localparam int SX_W        = 19;
    localparam int SY_W        = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int DIV_STEPS   = IDX_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LAYER_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TILESET_COLUMNS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_GID       = 3'd4;

    localparam logic [DIV_W-1:0] LAYER_WIDTH_RST     = 11'd1;
    localparam logic [PIX_W-1:0] TILE_WIDTH_RST      = 9'd32;
    localparam logic [PIX_W-1:0] TILE_HEIGHT_RST     = 9'd32;
    localparam logic [DIV_W-1:0] TILESET_COLUMNS_RST = 11'd1;
    localparam logic [IDX_W-1:0] FIRST_GID_RST       = 16'd1;

    typedef enum logic [1:0] {
        CORNER_TL = 2'd0,
        CORNER_TR = 2'd1,
        CORNER_BR = 2'd2,
        CORNER_BL = 2'd3
    } corner_t;

    typedef struct packed {
        logic             map_start;
        logic [IDX_W-1:0] tile_value;
    } tile_t;

    typedef struct packed {
        logic [IDX_W-1:0] tile_index;
        logic [1:0]       corner;
        logic [SX_W-1:0]  screen_x;
        logic [SY_W-1:0]  screen_y;
        logic [SX_W-1:0]  tex_x;
        logic [SY_W-1:0]  tex_y;
        logic             last;
    } vertex_t;

    typedef struct packed {
        logic [DIV_W-1:0] layer_width;
        logic [PIX_W-1:0] tile_width;
        logic [PIX_W-1:0] tile_height;
        logic [DIV_W-1:0] tileset_columns;
        logic [IDX_W-1:0] first_gid;
    } cfg_t;

    // one non-empty tile waiting for the back end
    typedef struct packed {
        logic [IDX_W-1:0] tile_index;
        logic [IDX_W-1:0] sprite;
    } job_t;

    // queue status seen by both ends
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* rtl/tqvg_div.sv */
// ---------------------------------------------------------------------------
// tqvg_div
// Restoring divider, one quotient bit per cycle; holds results until restart.
// ---------------------------------------------------------------------------
module tqvg_div
    import tqvg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IDX_W-1:0] dividend,
    input  logic [DIV_W-1:0] divisor,
    output logic             done,
    output logic [IDX_W-1:0] quotient,
    output logic [DIV_W-1:0] remainder
);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [IDX_W-1:0]  quo_reg;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  dvs_reg;

    logic [DIV_W:0]    trial;
    logic              fits;
    logic [DIV_W-1:0]  rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[IDX_W-1]};
        fits     = (trial >= {1'b0, dvs_reg});
        rem_next = fits ? DIV_W'(trial - {1'b0, dvs_reg}) : trial[DIV_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            // shift the next dividend bit in, record the quotient bit
            quo_reg <= {quo_reg[IDX_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* rtl/tqvg_queue.sv */
// ---------------------------------------------------------------------------
// tqvg_queue
// Short FIFO of tile jobs between the front and back ends.
// ---------------------------------------------------------------------------
module tqvg_queue
    import tqvg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  job_t   push_job,
    input  logic   pop,
    output job_t   head_job,
    output qstat_t status
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job     = entry_reg[rd_ptr_reg];
    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);

endmodule

/* rtl/tqvg_front.sv */
// ---------------------------------------------------------------------------
// tqvg_front
// Accepts tiles, keeps the map counter and drops empty tiles.
// ---------------------------------------------------------------------------
module tqvg_front
    import tqvg_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             tile_valid,
    output logic             tile_ready,
    input  tile_t            tile,
    input  logic [IDX_W-1:0] first_gid,
    input  qstat_t           qstat,
    output logic             push,
    output job_t             push_job
);

    logic [IDX_W-1:0] counter_reg;
    logic [IDX_W-1:0] idx;
    logic             accept;
    logic             blank;

    assign tile_ready = !qstat.full;
    assign accept     = tile_valid && tile_ready;
    assign idx        = tile.map_start ? '0 : counter_reg;
    // empty cell, or an id below the tileset's first sprite
    assign blank      = (tile.tile_value == '0) || (tile.tile_value < first_gid);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
        end
        else if (accept)
        begin
            counter_reg <= idx + 1'b1;
        end
    end

    assign push                = accept && !blank;
    assign push_job.tile_index = idx;
    assign push_job.sprite     = tile.tile_value - first_gid;

endmodule

/* rtl/tqvg_back.sv */
// ---------------------------------------------------------------------------
// tqvg_back
// Splits map and sprite positions, then emits the four quad corners.
// ---------------------------------------------------------------------------
module tqvg_back
    import tqvg_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  qstat_t  qstat,
    input  job_t    head_job,
    output logic    pop,
    output logic    vertex_valid,
    input  logic    vertex_ready,
    output vertex_t vertex
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_EMIT = 3'b100
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    corner_t          corner_reg;
    logic [IDX_W-1:0] idx_reg;
    logic             out_valid_reg;
    vertex_t          out_reg;

    logic             map_done;
    logic             spr_done;
    logic [IDX_W-1:0] map_row;
    logic [DIV_W-1:0] map_col;
    logic [IDX_W-1:0] spr_row;
    logic [DIV_W-1:0] spr_col;
    logic [DIV_W-1:0] lw_nz;
    logic [DIV_W-1:0] tc_nz;

    logic             load;
    logic             dx;
    logic             dy;
    logic [DIV_W:0]   map_col_d;
    logic [DIV_W:0]   spr_col_d;
    logic [IDX_W:0]   map_row_d;
    logic [IDX_W:0]   spr_row_d;
    logic [DIV_W+PIX_W:0] sx_prod;
    logic [DIV_W+PIX_W:0] tx_prod;
    logic [IDX_W+PIX_W:0] sy_prod;
    logic [IDX_W+PIX_W:0] ty_prod;

    // a zero divisor acts as one
    assign lw_nz = (cfg.layer_width == '0) ? DIV_W'(1) : cfg.layer_width;
    assign tc_nz = (cfg.tileset_columns == '0) ? DIV_W'(1) : cfg.tileset_columns;

    assign pop = (state_reg == ST_IDLE) && !qstat.empty;

    tqvg_div u_map_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pop),
        .dividend  (head_job.tile_index),
        .divisor   (lw_nz),
        .done      (map_done),
        .quotient  (map_row),
        .remainder (map_col)
    );

    tqvg_div u_spr_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (pop),
        .dividend  (head_job.sprite),
        .divisor   (tc_nz),
        .done      (spr_done),
        .quotient  (spr_row),
        .remainder (spr_col)
    );

    assign load = (state_reg == ST_EMIT) && (!out_valid_reg || vertex_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (map_done && spr_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (load && (corner_reg == CORNER_BL))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        dx        = (corner_reg == CORNER_TR) || (corner_reg == CORNER_BR);
        dy        = (corner_reg == CORNER_BR) || (corner_reg == CORNER_BL);
        map_col_d = {1'b0, map_col} + (DIV_W + 1)'(dx);
        spr_col_d = {1'b0, spr_col} + (DIV_W + 1)'(dx);
        map_row_d = {1'b0, map_row} + (IDX_W + 1)'(dy);
        spr_row_d = {1'b0, spr_row} + (IDX_W + 1)'(dy);
        sx_prod   = map_col_d * cfg.tile_width;
        tx_prod   = spr_col_d * cfg.tile_width;
        sy_prod   = map_row_d * cfg.tile_height;
        ty_prod   = spr_row_d * cfg.tile_height;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            corner_reg    <= CORNER_TL;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_DIV)
            begin
                corner_reg <= CORNER_TL;
            end
            else if (load)
            begin
                corner_reg <= corner_t'(corner_reg + 1'b1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vertex_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            idx_reg <= head_job.tile_index;
        end
        if (load)
        begin
            out_reg.tile_index <= idx_reg;
            out_reg.corner     <= corner_reg;
            out_reg.screen_x   <= sx_prod[SX_W-1:0];
            out_reg.screen_y   <= sy_prod[SY_W-1:0];
            out_reg.tex_x      <= tx_prod[SX_W-1:0];
            out_reg.tex_y      <= ty_prod[SY_W-1:0];
            out_reg.last       <= (corner_reg == CORNER_BL);
        end
    end

    assign vertex_valid = out_valid_reg;
    assign vertex       = out_reg;

endmodule

/* rtl/tile_quad_vertex_generator_unit.sv */
// ---------------------------------------------------------------------------
// tile_quad_vertex_generator_unit
// Turns a row-major stream of map tile ids into textured quad vertices.
// ---------------------------------------------------------------------------
// Usage:
//   tile   : one map cell per transfer (map_start, tile_value). map_start
//            makes the cell tile 0 of a new map; otherwise the index runs on
//            from the previous cell and wraps at 65536.
//   vertex : four transfers per non-empty tile, corners TL, TR, BR, BL, with
//            last set on BL. Empty cells (id 0 or below first_gid) give none.
//   cfg    : register writes (layer_width, tile_width, tile_height,
//            tileset_columns, first_gid); always ready, write only when idle.
// Back end: takes one non-empty tile at a time and holds it while the two
//   16-step shift-subtract dividers split map index and sprite number into
//   row and column, and until its BL corner is loaded. Empty tiles are
//   dropped at the front and never reach the back end.
//   A two-entry queue lets the front keep taking tiles while the back works.
// Reset: clears the tile counter, queue and sequencer, and loads the
//   register defaults (1, 32, 32, 1, 1).
// Stall: a vertex held by the receiver stays in the output register; the
//   back end pauses, the queue fills and then tile_ready drops.
// ---------------------------------------------------------------------------
module tile_quad_vertex_generator_unit
    import tqvg_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  tile_valid,
    output logic                  tile_ready,
    input  tile_t                 tile,
    output logic                  vertex_valid,
    input  logic                  vertex_ready,
    output vertex_t               vertex,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t   cfg_reg;
    qstat_t qstat;
    logic   push;
    job_t   push_job;
    logic   pop;
    job_t   head_job;

    // register writes are always accepted; unknown indexes are dropped
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_width     <= LAYER_WIDTH_RST;
            cfg_reg.tile_width      <= TILE_WIDTH_RST;
            cfg_reg.tile_height     <= TILE_HEIGHT_RST;
            cfg_reg.tileset_columns <= TILESET_COLUMNS_RST;
            cfg_reg.first_gid       <= FIRST_GID_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_LAYER_WIDTH:     cfg_reg.layer_width     <= cfg_data[DIV_W-1:0];
                REG_TILE_WIDTH:      cfg_reg.tile_width      <= cfg_data[PIX_W-1:0];
                REG_TILE_HEIGHT:     cfg_reg.tile_height     <= cfg_data[PIX_W-1:0];
                REG_TILESET_COLUMNS: cfg_reg.tileset_columns <= cfg_data[DIV_W-1:0];
                REG_FIRST_GID:       cfg_reg.first_gid       <= cfg_data[IDX_W-1:0];
                default:
                begin
                    // hold: no register at this index
                end
            endcase
        end
    end

    // front: take tiles, advance the map counter, drop empty cells
    tqvg_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .tile_valid (tile_valid),
        .tile_ready (tile_ready),
        .tile       (tile),
        .first_gid  (cfg_reg.first_gid),
        .qstat      (qstat),
        .push       (push),
        .push_job   (push_job)
    );

    tqvg_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .status   (qstat)
    );

    // back: divide, then sequence the four corners into the output register
    tqvg_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .head_job     (head_job),
        .pop          (pop),
        .vertex_valid (vertex_valid),
        .vertex_ready (vertex_ready),
        .vertex       (vertex)
    );

endmodule
